/* hdl/spq_pkg.sv */
// Package for the stable priority queue: widths, status codes and the
// per-cell control struct. No dependencies.
package spq_pkg;

   localparam int DEPTH_DEF        = 16;
   localparam int PAYLOAD_BITS_DEF = 32;

   localparam int PRIO_W    = 4;
   localparam int PORT_W    = 32;
   localparam int STATUS_W  = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [PRIO_W-1:0] prio;
   } cell_ctl_type;

endpackage

/* hdl/spq_cell.sv */
// One slot of the sorted queue chain. Holds a priority and a payload and
// trades them with its neighbors. Depends on spq_pkg.
module spq_cell #(
   parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                        clock,
   input  spq_pkg::cell_ctl_type       ctl,
   input  logic [PAYLOAD_BITS-1:0]     new_payload,
   input  logic                        occupied,
   input  logic                        left_after,
   input  logic [spq_pkg::PRIO_W-1:0]  left_prio,
   input  logic [PAYLOAD_BITS-1:0]     left_payload,
   input  logic [spq_pkg::PRIO_W-1:0]  right_prio,
   input  logic [PAYLOAD_BITS-1:0]     right_payload,
   output logic                        after,
   output logic [spq_pkg::PRIO_W-1:0]  prio,
   output logic [PAYLOAD_BITS-1:0]     payload
);
   import spq_pkg::*;

   logic [PRIO_W-1:0]       prio_ff, prio_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;

   // slot lies at or past the insertion point: empty or strictly worse
   assign after = !occupied || (prio_ff > ctl.prio);

   always_comb begin
      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (ctl.push && after) begin
         if (left_after) begin
            // shift the left neighbor down one slot
            prio_in    = left_prio;
            payload_in = left_payload;
         end else begin
            prio_in    = ctl.prio;
            payload_in = new_payload;
         end
      end else if (ctl.pop) begin
         // advance toward the head
         prio_in    = right_prio;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

   assign prio    = prio_ff;
   assign payload = payload_ff;

endmodule

/* hdl/stable_priority_queue.sv */
// Stable priority queue: a chain of DEPTH cells kept sorted, head in cell 0.
// The result beat is registered and appears in the cycle after the request beat is accepted.
// Throughput: one push or pop per cycle; every cell compares and moves in
// parallel, so the rate is set only by the result register draining.
// Reset (synchronous, active high) empties the queue and drops any pending
// result beat; the cell contents are not cleared. Depends on spq_pkg, spq_cell.
module stable_priority_queue #(
   parameter int DEPTH        = spq_pkg::DEPTH_DEF,
   parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [spq_pkg::PRIO_W-1:0]    req_priority_req,
   input  logic [spq_pkg::PORT_W-1:0]    req_payload,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [spq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [spq_pkg::PRIO_W-1:0]    rsp_out_priority,
   output logic [spq_pkg::PORT_W-1:0]    rsp_out_payload,
   output logic                          rsp_now_empty
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   // occupancy: cells below the count hold live entries
   logic [CNT_W-1:0] count_ff, count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [PRIO_W-1:0]       opri_ff, opri_in;
   logic [PORT_W-1:0]       opay_ff, opay_in;
   logic                    empty_ff, empty_in;

   logic                    accept;
   logic                    full;
   logic                    empty;
   cell_ctl_type            ctl;
   logic [PAYLOAD_BITS-1:0] new_payload;
   logic [PORT_W-1:0]       head_payload;

   logic [PRIO_W-1:0]       cell_prio    [DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
   logic                    cell_after   [DEPTH];

   // hold the request side while a result beat waits to be taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   assign ctl.push = accept && (req_op == OP_PUSH) && !full;
   assign ctl.pop  = accept && (req_op == OP_POP) && !empty;
   assign ctl.prio = req_priority_req;

   // fit the port-width tag into the stored width and back
   generate
      if (PAYLOAD_BITS <= PORT_W) begin : g_narrow
         assign new_payload  = req_payload[PAYLOAD_BITS-1:0];
         assign head_payload = PORT_W'(cell_payload[0]);
      end else begin : g_wide
         assign new_payload  = PAYLOAD_BITS'(req_payload);
         assign head_payload = cell_payload[0][PORT_W-1:0];
      end
   endgenerate

   // the cell chain: each cell sees its left and right neighbor
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic                    l_after;
         logic [PRIO_W-1:0]       l_prio;
         logic [PAYLOAD_BITS-1:0] l_payload;
         logic [PRIO_W-1:0]       r_prio;
         logic [PAYLOAD_BITS-1:0] r_payload;

         if (i == 0) begin : g_first
            // nothing to the left: the head takes the new entry directly
            assign l_after   = 1'b0;
            assign l_prio    = '0;
            assign l_payload = '0;
         end else begin : g_mid
            assign l_after   = cell_after[i-1];
            assign l_prio    = cell_prio[i-1];
            assign l_payload = cell_payload[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            // past the tail: contents are dead once the count drops
            assign r_prio    = '0;
            assign r_payload = '0;
         end else begin : g_inner
            assign r_prio    = cell_prio[i+1];
            assign r_payload = cell_payload[i+1];
         end

         spq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
         ) u_cell (
            .clock         (clock),
            .ctl           (ctl),
            .new_payload   (new_payload),
            .occupied      (CNT_W'(i) < count_ff),
            .left_after    (l_after),
            .left_prio     (l_prio),
            .left_payload  (l_payload),
            .right_prio    (r_prio),
            .right_payload (r_payload),
            .after         (cell_after[i]),
            .prio          (cell_prio[i]),
            .payload       (cell_payload[i])
         );
      end
   endgenerate

   // count and result beat
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      opri_in      = opri_ff;
      opay_in      = opay_ff;
      empty_in     = empty_ff;
      if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         opri_in      = '0;
         opay_in      = '0;
         if (req_op == OP_PUSH) begin
            if (full) begin
               status_in = ST_FULL;
            end
         end else if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            // return the head entry
            opri_in = cell_prio[0];
            opay_in = head_payload;
         end
         empty_in = (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      opri_ff   <= opri_in;
      opay_ff   <= opay_in;
      empty_ff  <= empty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_priority = opri_ff;
   assign rsp_out_payload  = opay_ff;
   assign rsp_now_empty    = empty_ff;

endmodule
